// ----- rtl/ovt_pkg.sv -----
// Shared types and constants for the object version table.
`default_nettype none

package ovt_pkg;

  // Field widths
  localparam int unsigned OP_W         = 2;
  localparam int unsigned KEY_W        = 64;
  localparam int unsigned VER_W        = 64;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned IN_TDATA_W   = 72;
  localparam int unsigned OUT_TDATA_W  = 72;
  localparam int unsigned IN_USED_W    = OP_W + KEY_W;
  localparam int unsigned OUT_USED_W   = VER_W + STATUS_W;

  // Request codes
  typedef enum logic [OP_W-1:0] {
    OP_START  = 2'd0,
    OP_GETVER = 2'd1,
    OP_COMMIT = 2'd2
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // Source of the result value
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_COUNT,
    RES_VERSION
  } res_sel_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // One table entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VER_W-1:0] version;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      id_load;
    logic      scan_start;
    logic      scan_step;
    logic      wr_commit;
    logic      wr_insert;
    logic      res_load;
    res_sel_t  res_sel;
    status_t   res_status;
    logic      out_load;
  } ovt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;
    logic miss;
    logic full;
    logic out_busy;
  } ovt_stat_t;

endpackage

`default_nettype wire

// ----- rtl/object_version_table_core.sv -----
// Object version table: top level joining the sequencer and the datapath.
// A start request or an unused code loads the pending result on the transfer and passes it to the output register.
// A get-version or commit request scans the filled entries one per cycle, up to the entry
// that matches or to the fill count on a miss, so at most TABLE_ENTRIES entries, and then
// passes its result to the output register; one item is in work at a time.
// Reset clears the fill count, the transaction counter and the output valid; no clearing pass.
`default_nettype none

module object_version_table_core #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [1:0] operation, [65:2] object_id, [71:66] zero
  input  wire logic [ovt_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [63:0] value, [65:64] status, [71:66] zero
  output logic [ovt_pkg::OUT_TDATA_W-1:0]        out_tdata
);
  import ovt_pkg::*;

  ovt_cmd_t  cmd;
  ovt_stat_t stat;

  ovt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tdata[OP_W-1:0]),
    .stat      (stat),
    .cmd       (cmd)
  );

  ovt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_object_id (in_tdata[IN_USED_W-1:OP_W]),
    .cmd          (cmd),
    .stat         (stat),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

endmodule

`default_nettype wire

// ----- rtl/ovt_ctrl.sv -----
// Request sequencer: accepts a request, runs the table scan and releases the result.
`default_nettype none

module ovt_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [ovt_pkg::OP_W-1:0] in_op,
  input  wire ovt_pkg::ovt_stat_t    stat,
  output ovt_pkg::ovt_cmd_t          cmd
);
  import ovt_pkg::*;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  op_t    in_op_e;
  logic   accept;

  assign in_op_e   = op_t'(in_op);
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // State and request code registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_START;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt = in_op_e;
          unique case (in_op_e) inside
            OP_GETVER, OP_COMMIT: state_nxt = S_SCAN;
            default:              state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (stat.hit || stat.miss) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd            = '0;
    cmd.res_sel    = RES_ZERO;
    cmd.res_status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.id_load = 1'b1;
          unique case (in_op_e) inside
            OP_START: begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_COUNT;
            end
            OP_GETVER, OP_COMMIT: cmd.scan_start = 1'b1;
            default:              cmd.res_load   = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.hit) begin
          cmd.res_load = 1'b1;
          if (op_r == OP_GETVER) begin
            cmd.res_sel = RES_VERSION;
          end else begin
            cmd.wr_commit = 1'b1;
          end
        end else if (stat.miss) begin
          cmd.res_load = 1'b1;
          if (op_r == OP_GETVER) begin
            if (stat.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.wr_insert = 1'b1;
            end
          end else begin
            cmd.res_status = ST_NOTFOUND;
          end
        end
      end
      S_DONE: begin
        cmd.out_load = !stat.out_busy;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/ovt_datapath.sv -----
// Table memory, scan pointer, fill count, transaction counter and result register.
`default_nettype none

module ovt_datapath #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [ovt_pkg::KEY_W-1:0]     in_object_id,
  input  wire ovt_pkg::ovt_cmd_t             cmd,
  output ovt_pkg::ovt_stat_t                 stat,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [ovt_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import ovt_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  entry_t                mem [TABLE_ENTRIES];
  entry_t                rd_data_r;
  logic [IDX_W-1:0]      rd_addr_r;
  logic [IDX_W-1:0]      cmp_idx_r;
  logic                  cmp_vld_r;
  logic [CNT_W-1:0]      fill_r;
  logic [VER_W-1:0]      cnt_r;
  logic [KEY_W-1:0]      id_r;
  logic [VER_W-1:0]      res_value_r;
  status_t               res_status_r;
  logic                  out_tvalid_r;
  logic [OUT_USED_W-1:0] out_data_r;
  logic                  match;
  logic                  last_cmp;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  entry_t                wr_data;
  logic [VER_W-1:0]      cnt_inc;

  // Compare the entry read last cycle
  assign match    = cmp_vld_r && (rd_data_r.key == id_r);
  assign last_cmp = cmp_vld_r && ((CNT_W'(cmp_idx_r) + CNT_W'(1)) == fill_r);
  assign cnt_inc  = cnt_r + VER_W'(1);

  assign stat.hit      = match;
  assign stat.miss     = (fill_r == '0) || (last_cmp && !match);
  assign stat.full     = (fill_r == FULL_CNT);
  assign stat.out_busy = out_tvalid_r && !out_tready;

  // Select the table write
  always_comb begin
    wr_en   = cmd.wr_commit || cmd.wr_insert;
    wr_addr = cmp_idx_r;
    wr_data = rd_data_r;
    wr_data.version = rd_data_r.version + VER_W'(1);
    if (cmd.wr_insert) begin
      wr_addr         = fill_r[IDX_W-1:0];
      wr_data.key     = id_r;
      wr_data.version = '0;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr_r];
  end

  // Scan pointer and compare stage
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      rd_addr_r <= '0;
      cmp_vld_r <= 1'b0;
    end else if (cmd.scan_step) begin
      if (rd_addr_r != LAST_IDX) begin
        rd_addr_r <= rd_addr_r + IDX_W'(1);
      end
      cmp_idx_r <= rd_addr_r;
      cmp_vld_r <= (CNT_W'(rd_addr_r) < fill_r);
    end
  end

  // Hold the requested identifier
  always_ff @(posedge clk) begin
    if (cmd.id_load) begin
      id_r <= in_object_id;
    end
  end

  // Fill count and transaction counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (cmd.wr_insert) begin
        fill_r <= fill_r + CNT_W'(1);
      end
      if (cmd.res_load && (cmd.res_sel == RES_COUNT)) begin
        cnt_r <= cnt_inc;
      end
    end
  end

  // Pending result
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      case (cmd.res_sel)
        RES_COUNT:   res_value_r <= cnt_inc;
        RES_VERSION: res_value_r <= rd_data_r.version;
        default:     res_value_r <= '0;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {res_status_r, res_value_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

endmodule

`default_nettype wire

// ----- rtl/ovt_checker.sv -----
// Port-level checks for the object version table, bound to the top level.
`default_nettype none

module ovt_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [ovt_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ovt_pkg::*;

  // Stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Stalled result keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // Status is always a defined code and padding is zero
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_USED_W-1:VER_W] <= ST_FULL) &&
                   (out_tdata[OUT_TDATA_W-1:OUT_USED_W] == '0))
    else $error("bad status code or padding");

  // An error status carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[OUT_USED_W-1:VER_W] != ST_OK) |-> out_tdata[VER_W-1:0] == '0)
    else $error("error result with nonzero value");

  // A transfer in leaves the block busy in the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in work");

endmodule

bind object_version_table_core ovt_checker u_ovt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
